// File: hdl/bpms_pkg.sv
// ----------------------------------------------------------------------------
// bpms_pkg
// Shared types, constants and helpers for the point motion step pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package bpms_pkg;

  localparam int unsigned FRAC_BITS   = 28;
  localparam int unsigned COLOUR_BITS = 16;
  localparam int unsigned SQ_SHIFT    = 2 * FRAC_BITS - 2 * COLOUR_BITS;
  localparam int unsigned OVER_BIT    = 2 * FRAC_BITS;
  localparam int unsigned NUM_STEPS   = COLOUR_BITS;
  localparam int unsigned ADDR_W      = 5;

  localparam logic [16:0] COLOUR_ONE  = 17'h10000;
  localparam logic [16:0] COLOUR_HALF = 17'h08000;

  localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    REG_ACCEL_X   = 3'd0,
    REG_ACCEL_Y   = 3'd1,
    REG_TIME_STEP = 3'd2,
    REG_LIMIT_X   = 3'd3,
    REG_LIMIT_Y   = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               want_colour;
  } bpms_in_t;

  typedef struct packed {
    logic signed [31:0] new_pos_x;
    logic signed [31:0] new_pos_y;
    logic signed [31:0] new_vel_x;
    logic signed [31:0] new_vel_y;
    logic [16:0]        red;
    logic [16:0]        green;
    logic [16:0]        blue;
    logic               colour_valid;
  } bpms_out_t;

  typedef struct packed {
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic [30:0]        time_step;
    logic [30:0]        limit_x;
    logic [30:0]        limit_y;
  } bpms_cfg_t;

  // state carried through the digit-serial colour stages
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic               want;
    logic               zero_x;
    logic               zero_y;
    logic               over;
    logic [31:0]        rem_x;
    logic [31:0]        den_x;
    logic [16:0]        q_x;
    logic [31:0]        rem_y;
    logic [31:0]        den_y;
    logic [16:0]        q_y;
    logic [31:0]        rad;
    logic [17:0]        srem;
    logic [15:0]        root;
  } bpms_col_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [31:0] r;
    if (v > 36'(S32_MAX)) begin
      r = S32_MAX;
    end else if (v < 36'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: hdl/bpms_cfg_regs.sv
// ----------------------------------------------------------------------------
// bpms_cfg_regs
// APB register file: accelerations, time step and range limits.
// ----------------------------------------------------------------------------
`default_nettype none

module bpms_cfg_regs (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bpms_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready,
  output bpms_pkg::bpms_cfg_t              cfg_o
);

  bpms_pkg::bpms_cfg_t cfg_q, cfg_d;
  bpms_pkg::reg_idx_e  idx;
  logic                wr_en;

  assign idx    = bpms_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        bpms_pkg::REG_ACCEL_X:   cfg_d.accel_x   = pwdata;
        bpms_pkg::REG_ACCEL_Y:   cfg_d.accel_y   = pwdata;
        bpms_pkg::REG_TIME_STEP: cfg_d.time_step = pwdata[30:0];
        bpms_pkg::REG_LIMIT_X:   cfg_d.limit_x   = pwdata[30:0];
        bpms_pkg::REG_LIMIT_Y:   cfg_d.limit_y   = pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      bpms_pkg::REG_ACCEL_X:   prdata = cfg_q.accel_x;
      bpms_pkg::REG_ACCEL_Y:   prdata = cfg_q.accel_y;
      bpms_pkg::REG_TIME_STEP: prdata = {1'b0, cfg_q.time_step};
      bpms_pkg::REG_LIMIT_X:   prdata = {1'b0, cfg_q.limit_x};
      bpms_pkg::REG_LIMIT_Y:   prdata = {1'b0, cfg_q.limit_y};
      default:                 prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_x   <= 32'sd268435456;
      cfg_q.accel_y   <= 32'sd0;
      cfg_q.time_step <= 31'd26844;
      cfg_q.limit_x   <= 31'd268435456;
      cfg_q.limit_y   <= 31'd134217728;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// File: hdl/bpms_axis.sv
// ----------------------------------------------------------------------------
// bpms_axis
// Five-stage motion datapath for one axis: Euler step, saturate, clamp, bounce.
// ----------------------------------------------------------------------------
`default_nettype none

module bpms_axis (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [31:0] pos_i,
  input  wire logic signed [31:0] vel_i,
  input  wire logic signed [31:0] accel_i,
  input  wire logic        [30:0] dt_i,
  input  wire logic        [30:0] lim_i,
  output logic      signed [31:0] pos_o,
  output logic      signed [31:0] vel_o
);

  logic signed [31:0] dt_s;
  assign dt_s = $signed({1'b0, dt_i});

  // stage 1: a*dt
  logic signed [63:0] prod_q, prod_d;
  logic signed [31:0] p1_q, v1_q;
  assign prod_d = accel_i * dt_s;

  // stage 2: v + a*dt/2 and v + a*dt
  logic signed [35:0] half_s, inc_s;
  logic signed [31:0] term_d, term_q, nv_d, nv2_q, p2_q;
  assign half_s = 36'(prod_q >>> (bpms_pkg::FRAC_BITS + 1));
  assign inc_s  = 36'(prod_q >>> bpms_pkg::FRAC_BITS);
  assign term_d = bpms_pkg::sat32(36'(v1_q) + half_s);
  assign nv_d   = bpms_pkg::sat32(36'(v1_q) + inc_s);

  // stage 3: term*dt
  logic signed [63:0] tdt_d, tdt_q;
  logic signed [31:0] p3_q, nv3_q;
  assign tdt_d = term_q * dt_s;

  // stage 4: new position
  logic signed [31:0] np_d, np4_q, nv4_q;
  assign np_d = bpms_pkg::sat32(36'(p3_q) + 36'(tdt_q >>> bpms_pkg::FRAC_BITS));

  // stage 5: clamp and bounce
  logic signed [32:0] lim_s, np_s;
  logic signed [31:0] neg_v, pos5_d, vel5_d, pos5_q, vel5_q;
  assign lim_s = $signed({2'b00, lim_i});
  assign np_s  = 33'(np4_q);
  assign neg_v = (nv4_q == bpms_pkg::S32_MIN) ? bpms_pkg::S32_MAX : -nv4_q;

  always_comb begin
    pos5_d = np4_q;
    vel5_d = nv4_q;
    if (np_s > lim_s) begin
      pos5_d = {1'b0, lim_i};
      if (!nv4_q[31]) vel5_d = neg_v;
    end else if (np_s < -lim_s) begin
      pos5_d = 32'(-lim_s);
      if (nv4_q[31] || nv4_q == 32'sd0) vel5_d = neg_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      p1_q   <= pos_i;
      v1_q   <= vel_i;
      term_q <= term_d;
      nv2_q  <= nv_d;
      p2_q   <= p1_q;
      tdt_q  <= tdt_d;
      p3_q   <= p2_q;
      nv3_q  <= nv2_q;
      np4_q  <= np_d;
      nv4_q  <= nv3_q;
      pos5_q <= pos5_d;
      vel5_q <= vel5_d;
    end
  end

  assign pos_o = pos5_q;
  assign vel_o = vel5_q;

endmodule

`default_nettype wire

// File: hdl/bpms_colour_step.sv
// ----------------------------------------------------------------------------
// bpms_colour_step
// One pipeline stage of the colour unit: one quotient bit per axis and one
// square-root digit.
// ----------------------------------------------------------------------------
`default_nettype none

module bpms_colour_step (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire bpms_pkg::bpms_col_t col_i,
  output bpms_pkg::bpms_col_t      col_o
);

  bpms_pkg::bpms_col_t col_d, col_q;
  logic [32:0] rx2, ry2;
  logic [19:0] cur, trial;

  always_comb begin
    col_d = col_i;
    // restoring divide, one bit
    rx2 = {col_i.rem_x, 1'b0};
    if (rx2 >= {1'b0, col_i.den_x}) begin
      col_d.rem_x = 32'(rx2 - {1'b0, col_i.den_x});
      col_d.q_x   = {col_i.q_x[15:0], 1'b1};
    end else begin
      col_d.rem_x = rx2[31:0];
      col_d.q_x   = {col_i.q_x[15:0], 1'b0};
    end
    ry2 = {col_i.rem_y, 1'b0};
    if (ry2 >= {1'b0, col_i.den_y}) begin
      col_d.rem_y = 32'(ry2 - {1'b0, col_i.den_y});
      col_d.q_y   = {col_i.q_y[15:0], 1'b1};
    end else begin
      col_d.rem_y = ry2[31:0];
      col_d.q_y   = {col_i.q_y[15:0], 1'b0};
    end
    // square root, one digit
    cur   = {col_i.srem, col_i.rad[31:30]};
    trial = {2'b00, col_i.root, 2'b01};
    if (cur >= trial) begin
      col_d.srem = 18'(cur - trial);
      col_d.root = {col_i.root[14:0], 1'b1};
    end else begin
      col_d.srem = cur[17:0];
      col_d.root = {col_i.root[14:0], 1'b0};
    end
    col_d.rad = {col_i.rad[29:0], 2'b00};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

`default_nettype wire

// File: hdl/bouncing_point_motion_step_core.sv
// ----------------------------------------------------------------------------
// bouncing_point_motion_step_core
// Euler step of a 2D point with wall bounce, plus optional colour output.
// ----------------------------------------------------------------------------
//  channel | handshake                 | payload
//  in      | in_valid_i / in_ready_o   | in_data_i  (bpms_in_t)
//  out     | out_valid_o / out_ready_i | out_data_o (bpms_out_t)
//  cfg     | APB psel/penable/pready   | paddr, pwdata, prdata
//
//  One beat enters per cycle unless the output stalls. Stages: five motion
//  stages, squares, sum, sixteen digit-serial divide/root stages, output
//  register. The colour digit stages set the depth. On a stall the whole
//  pipeline holds. Reset clears valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module bouncing_point_motion_step_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire bpms_pkg::bpms_in_t          in_data_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output bpms_pkg::bpms_out_t              out_data_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [bpms_pkg::ADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);

  localparam int unsigned NSTAGE = 8 + bpms_pkg::NUM_STEPS;

  bpms_pkg::bpms_cfg_t cfg;
  logic                en;
  logic [NSTAGE-1:0]   vld_q, vld_d;
  logic [4:0]          want_q;

  bpms_cfg_regs u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata,
    .prdata, .pready, .cfg_o(cfg)
  );

  assign en         = !vld_q[NSTAGE-1] || out_ready_i;
  assign in_ready_o = en;
  assign vld_d      = {vld_q[NSTAGE-2:0], in_valid_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  logic signed [31:0] px5, py5, vx5, vy5;

  bpms_axis u_axis_x (
    .clk_i, .en_i(en), .pos_i(in_data_i.pos_x), .vel_i(in_data_i.vel_x),
    .accel_i(cfg.accel_x), .dt_i(cfg.time_step), .lim_i(cfg.limit_x),
    .pos_o(px5), .vel_o(vx5)
  );

  bpms_axis u_axis_y (
    .clk_i, .en_i(en), .pos_i(in_data_i.pos_y), .vel_i(in_data_i.vel_y),
    .accel_i(cfg.accel_y), .dt_i(cfg.time_step), .lim_i(cfg.limit_y),
    .pos_o(py5), .vel_o(vy5)
  );

  // stage 6: divide setup (top quotient bit) and squares of speed
  logic [31:0] xx, xy, dx, dy, ax, ay;
  logic        qx16, qy16;
  logic [63:0] sqx_q, sqy_q;
  bpms_pkg::bpms_col_t c6_d, c6_q, c7_d, c7_q;

  assign xx   = 32'($signed(33'(px5)) + $signed({2'b00, cfg.limit_x}));
  assign xy   = 32'($signed(33'(py5)) + $signed({2'b00, cfg.limit_y}));
  assign dx   = {cfg.limit_x, 1'b0};
  assign dy   = {cfg.limit_y, 1'b0};
  assign qx16 = xx >= dx;
  assign qy16 = xy >= dy;
  assign ax   = vx5[31] ? 32'(-vx5) : vx5;
  assign ay   = vy5[31] ? 32'(-vy5) : vy5;

  always_comb begin
    c6_d        = '0;
    c6_d.pos_x  = px5;
    c6_d.pos_y  = py5;
    c6_d.vel_x  = vx5;
    c6_d.vel_y  = vy5;
    c6_d.want   = want_q[4];
    c6_d.zero_x = cfg.limit_x == '0;
    c6_d.zero_y = cfg.limit_y == '0;
    c6_d.den_x  = dx;
    c6_d.den_y  = dy;
    c6_d.q_x    = {16'd0, qx16};
    c6_d.q_y    = {16'd0, qy16};
    c6_d.rem_x  = qx16 ? xx - dx : xx;
    c6_d.rem_y  = qy16 ? xy - dy : xy;
  end

  // stage 7: sum of squares, overflow check, root operand
  logic [63:0] sum;
  assign sum = sqx_q + sqy_q;

  always_comb begin
    c7_d      = c6_q;
    c7_d.over = |sum[63:bpms_pkg::OVER_BIT];
    c7_d.rad  = sum[bpms_pkg::SQ_SHIFT+31:bpms_pkg::SQ_SHIFT];
    c7_d.srem = '0;
    c7_d.root = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      want_q <= {want_q[3:0], in_data_i.want_colour};
      c6_q   <= c6_d;
      sqx_q  <= ax * ax;
      sqy_q  <= ay * ay;
      c7_q   <= c7_d;
    end
  end

  bpms_pkg::bpms_col_t chain [bpms_pkg::NUM_STEPS+1];
  assign chain[0] = c7_q;

  for (genvar k = 0; k < bpms_pkg::NUM_STEPS; k++) begin : g_step
    bpms_colour_step u_step (
      .clk_i, .en_i(en), .col_i(chain[k]), .col_o(chain[k+1])
    );
  end

  // output register
  bpms_pkg::bpms_col_t cf;
  bpms_pkg::bpms_out_t out_d, out_q;
  assign cf = chain[bpms_pkg::NUM_STEPS];

  always_comb begin
    out_d.new_pos_x    = cf.pos_x;
    out_d.new_pos_y    = cf.pos_y;
    out_d.new_vel_x    = cf.vel_x;
    out_d.new_vel_y    = cf.vel_y;
    out_d.colour_valid = cf.want;
    out_d.red          = '0;
    out_d.green        = '0;
    out_d.blue         = '0;
    if (cf.want) begin
      out_d.red   = cf.zero_x ? bpms_pkg::COLOUR_HALF : cf.q_x;
      out_d.green = cf.zero_y ? bpms_pkg::COLOUR_HALF : cf.q_y;
      out_d.blue  = cf.over ? bpms_pkg::COLOUR_ONE : {1'b0, cf.root};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = vld_q[NSTAGE-1];
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stream test of the point motion step core: directed corner points, random
// points under several acceleration/step/limit settings, random valid/ready
// gaps and a long output stall. Each beat is checked against a local model.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY = 24;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  bpms_pkg::bpms_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  bpms_pkg::bpms_out_t out_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [bpms_pkg::ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  bouncing_point_motion_step_core uut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk = ~clk;

  // model copy of the registers
  logic signed [31:0] m_ax = 32'sd268435456, m_ay = '0;
  logic [30:0] m_dt = 31'd26844, m_lx = 31'd268435456, m_ly = 31'd134217728;

  bpms_pkg::bpms_out_t pending_steps[$];
  int errors = 0;
  int in_idle_pct = 34;
  int out_idle_pct = 34;
  int stall_cycles = 0;

  function automatic logic signed [63:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor-shift is >>> on a signed value
  function automatic void advance_axis(input logic signed [63:0] p, v, a, dt, lim,
                                       output logic signed [63:0] po, vo);
    logic signed [63:0] prod, half, inc, term, np, nv;
    prod = a * dt;
    half = prod >>> (bpms_pkg::FRAC_BITS + 1);
    inc  = prod >>> bpms_pkg::FRAC_BITS;
    term = clamp32(v + half);
    np = clamp32(p + ((term * dt) >>> bpms_pkg::FRAC_BITS));
    nv = clamp32(v + inc);
    if (np > lim) begin
      np = lim;
      if (nv >= 0) nv = clamp32(-nv);
    end else if (np < -lim) begin
      np = -lim;
      if (nv <= 0) nv = clamp32(-nv);
    end
    po = np;
    vo = nv;
  endfunction

  function automatic logic [16:0] scale_colour(logic signed [63:0] p, lim);
    logic [63:0] num;
    if (lim == 0) return bpms_pkg::COLOUR_HALF;
    num = 64'(p + lim) << bpms_pkg::COLOUR_BITS;
    return 17'(num / (64'(lim) * 2));
  endfunction

  function automatic logic [16:0] speed_shade(logic signed [63:0] vx, vy);
    logic [63:0] ax, ay, s, res, b;
    ax = vx < 0 ? -vx : vx;
    ay = vy < 0 ? -vy : vy;
    s = ax * ax + ay * ay;
    if (s >= (64'd1 << (2 * bpms_pkg::FRAC_BITS))) return bpms_pkg::COLOUR_ONE;
    s = s >> (2 * bpms_pkg::FRAC_BITS - 2 * bpms_pkg::COLOUR_BITS);
    res = 0;
    b = 64'd1 << 62;
    while (b > s) b >>= 2;
    while (b != 0) begin
      if (s >= res + b) begin
        s -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return 17'(res);
  endfunction

  function automatic bpms_pkg::bpms_out_t step_point(bpms_pkg::bpms_in_t d);
    bpms_pkg::bpms_out_t r;
    logic signed [63:0] px, py, vx, vy;
    advance_axis(64'(d.pos_x), 64'(d.vel_x), 64'(m_ax), 64'(m_dt), 64'(m_lx), px, vx);
    advance_axis(64'(d.pos_y), 64'(d.vel_y), 64'(m_ay), 64'(m_dt), 64'(m_ly), py, vy);
    r = '0;
    r.new_pos_x = px[31:0];
    r.new_pos_y = py[31:0];
    r.new_vel_x = vx[31:0];
    r.new_vel_y = vy[31:0];
    if (d.want_colour) begin
      r.red = scale_colour(px, 64'(m_lx));
      r.green = scale_colour(py, 64'(m_ly));
      r.blue = speed_shade(vx, vy);
      r.colour_valid = 1'b1;
    end
    return r;
  endfunction

  task automatic reg_write(input bpms_pkg::reg_idx_e idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      bpms_pkg::REG_ACCEL_X:   m_ax = val;
      bpms_pkg::REG_ACCEL_Y:   m_ay = val;
      bpms_pkg::REG_TIME_STEP: m_dt = val[30:0];
      bpms_pkg::REG_LIMIT_X:   m_lx = val[30:0];
      default:                 m_ly = val[30:0];
    endcase
  endtask

  // called at a falling edge; also drops the input after the last beat
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_steps.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_motion(input logic [31:0] ax, ay, dt, lx, ly);
    drain_results();
    reg_write(bpms_pkg::REG_ACCEL_X, ax);
    reg_write(bpms_pkg::REG_ACCEL_Y, ay);
    reg_write(bpms_pkg::REG_TIME_STEP, dt);
    reg_write(bpms_pkg::REG_LIMIT_X, lx);
    reg_write(bpms_pkg::REG_LIMIT_Y, ly);
  endtask

  // sender: called at a falling edge, returns at a falling edge with valid
  // still high; the next send or a drain decides what happens to it
  task automatic send_point(input bpms_pkg::bpms_in_t d);
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_steps = {pending_steps, step_point(d)};
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'(int'($urandom_range(65535)) - 32768);
      3: return 32'(int'($urandom_range(32'h2000_0000)) - 32'sh1000_0000);
      4: return 32'(int'($urandom_range(32'h0800_0000)) - 32'sh0400_0000);
      default: return $urandom();
    endcase
  endfunction

  function automatic bpms_pkg::bpms_in_t random_point();
    bpms_pkg::bpms_in_t d;
    d.pos_x = pick_word();
    d.pos_y = pick_word();
    d.vel_x = pick_word();
    d.vel_y = pick_word();
    d.want_colour = $urandom_range(3) != 0;
    return d;
  endfunction

  // receiver
  always @(negedge clk) begin
    if (stall_cycles > 0) begin
      stall_cycles <= stall_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(99) >= out_idle_pct;
    end
  end

  always @(posedge clk) begin
    bpms_pkg::bpms_out_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_steps.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        e = pending_steps.pop_front();
        if (out_data.new_pos_x !== e.new_pos_x) begin
          $error("new_pos_x exp %h got %h", e.new_pos_x, out_data.new_pos_x); errors++;
        end
        if (out_data.new_pos_y !== e.new_pos_y) begin
          $error("new_pos_y exp %h got %h", e.new_pos_y, out_data.new_pos_y); errors++;
        end
        if (out_data.new_vel_x !== e.new_vel_x) begin
          $error("new_vel_x exp %h got %h", e.new_vel_x, out_data.new_vel_x); errors++;
        end
        if (out_data.new_vel_y !== e.new_vel_y) begin
          $error("new_vel_y exp %h got %h", e.new_vel_y, out_data.new_vel_y); errors++;
        end
        if (out_data.red !== e.red) begin
          $error("red exp %h got %h", e.red, out_data.red); errors++;
        end
        if (out_data.green !== e.green) begin
          $error("green exp %h got %h", e.green, out_data.green); errors++;
        end
        if (out_data.blue !== e.blue) begin
          $error("blue exp %h got %h", e.blue, out_data.blue); errors++;
        end
        if (out_data.colour_valid !== e.colour_valid) begin
          $error("colour_valid exp %b got %b", e.colour_valid, out_data.colour_valid);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    bpms_pkg::bpms_in_t d;
    logic [31:0] corners[4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};
    for (int i = 0; i < 8; i++) begin
      d.pos_x = corners[i % 4];
      d.pos_y = corners[(i + 1) % 4];
      d.vel_x = corners[(i + 2) % 4];
      d.vel_y = corners[(i + 3) % 4];
      d.want_colour = i[0];
      send_point(d);
    end
    // reflection of most negative velocity, slow point, fast point
    send_point('{32'sh1000_0000, -32'sh1000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b1});
    send_point('{32'sh0, 32'sh0, 32'sh100, -32'sh100, 1'b1});
    send_point('{32'sh0, 32'sh0, 32'sh1000_0000, 32'sh0, 1'b1});
    send_point('{32'sh0FFF_FFFF, 32'sh0, 32'sh7FFF_FFFF, 32'sh0, 1'b0});
    // zero limits, full step and extreme accelerations
    set_motion(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h0);
    for (int i = 0; i < 6; i++) send_point(random_point());
    set_motion(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    for (int i = 0; i < 6; i++) send_point(random_point());
  endtask

  task automatic test_random_settings();
    for (int phase = 0; phase < 6; phase++) begin
      set_motion(pick_word(), pick_word(),
                 phase[0] ? $urandom_range(32'h1000_0000) : $urandom_range(32'h10_0000),
                 1 + $urandom_range(32'h7FFF_FFFE), 1 + $urandom_range(32'h3000_0000));
      in_idle_pct = (phase == 3) ? 0 : 34;
      out_idle_pct = (phase == 3) ? 0 : 34;
      for (int i = 0; i < 200; i++) send_point(random_point());
    end
    in_idle_pct = 34;
    out_idle_pct = 34;
  endtask

  task automatic test_backpressure();
    set_motion(32'h1000_0000, 32'hF000_0000, 32'd26844, 32'h1000_0000, 32'h0800_0000);
    stall_cycles = 120;
    in_idle_pct = 0;
    for (int i = 0; i < 100; i++) send_point(random_point());
    in_idle_pct = 34;
    // sender waits for every result, then resumes
    drain_results();
    for (int i = 0; i < 100; i++) send_point(random_point());
  endtask

  initial begin
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random_settings();
    test_backpressure();
    drain_results();
    if (errors == 0) begin
      $display("** bouncing_point_motion_step_core: PASSED **");
    end else begin
      $display("** bouncing_point_motion_step_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("** bouncing_point_motion_step_core: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
